@@ sv/line_substring_matcher_assert.svh @@
// Assertion macros used by the port-level checker of the line substring matcher.
`ifndef LINE_SUBSTRING_MATCHER_ASSERT_SVH
`define LINE_SUBSTRING_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSM_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSM_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ sv/lsm_pkg.sv @@
// Shared types, codes and constants of the line substring matcher.
package lsm_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int LINE_BUFFER_DEF = 256;
	localparam int PATTERN_BYTES   = 16;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_EOF  = 1'b1
	} op_t;

	typedef enum logic {
		KIND_LINE    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		CFG_PATTERN_LOW  = 2'd0,
		CFG_PATTERN_HIGH = 2'd1,
		CFG_PATTERN_LEN  = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_index_t;

	// Results caused by one input item: an optional line report and an optional summary.
	typedef struct packed {
		logic        line_valid;
		logic [31:0] line_number;
		logic [31:0] line_hits;
		logic        sum_valid;
		logic [31:0] sum_hits;
	} group_t;

endpackage

@@ sv/lsm_matcher.sv @@
// Per-line match state, byte window and parallel pattern compare.
module lsm_matcher #(
	parameter int MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEF,
	parameter int LINE_BUFFER = lsm_pkg::LINE_BUFFER_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  lsm_pkg::op_t                          op,
	input  logic [7:0]                            data_byte,
	input  logic [8*lsm_pkg::PATTERN_BYTES-1:0]   pattern,
	input  logic [4:0]                            pattern_length,
	output logic                                  push,
	output lsm_pkg::group_t                       group
);
	import lsm_pkg::*;

	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int KEPT_W = $clog2(LINE_BUFFER);

	logic [7:0]        recent_q [MAX_PATTERN];
	logic [KEPT_W-1:0] kept_q;
	logic              cut_q;
	logic              matched_q;
	logic              pending_q;
	logic [31:0]       line_q;
	logic [31:0]       matches_q;

	logic [7:0]        win [MAX_PATTERN];
	logic [LEN_W-1:0]  eff_len;
	logic [4:0]        clamped_len;
	logic [MAX_PATTERN:0] eq_by_len;
	logic              eq_sel;
	logic [KEPT_W-1:0] kept_next;
	logic              hit;
	logic [31:0]       matches_inc;
	logic [31:0]       line_inc;
	logic              finish;
	logic              is_newline;
	logic              take;
	logic              cut_now;

	// Pattern ends at its first zero byte within the clamped length.
	always_comb begin
		clamped_len = (pattern_length > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : pattern_length;
		eff_len = LEN_W'(clamped_len);
		for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
			if ((5'(k) < clamped_len) && (pattern[8*k +: 8] == 8'd0)) begin
				eff_len = LEN_W'(k);
			end
		end
	end

	// Window as it stands once the new byte is shifted in.
	always_comb begin
		win[0] = data_byte;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win[i] = recent_q[i-1];
		end
	end

	// One comparator bank per possible pattern length, then pick the one in use.
	always_comb begin
		eq_by_len = '0;
		for (int l = 1; l <= MAX_PATTERN; l++) begin
			eq_by_len[l] = 1'b1;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				if (i < l) begin
					if (win[i] != pattern[8*(l-1-i) +: 8]) begin
						eq_by_len[l] = 1'b0;
					end
				end
			end
		end
		eq_sel = eq_by_len[eff_len];
	end

	assign kept_next   = kept_q + KEPT_W'(1);
	assign hit         = matched_q || (eff_len == '0);
	assign matches_inc = (hit && (matches_q != SAT32)) ? matches_q + 32'd1 : matches_q;
	assign line_inc    = (line_q != SAT32) ? line_q + 32'd1 : line_q;
	assign is_newline  = (op == OP_BYTE) && (data_byte == NEWLINE_BYTE);
	assign finish      = is_newline || ((op == OP_EOF) && pending_q);
	assign take        = (op == OP_BYTE) && !is_newline && !cut_q;
	assign cut_now     = (data_byte == 8'd0) || (kept_q >= KEPT_W'(LINE_BUFFER - 1));

	always_comb begin
		group.line_valid  = finish && hit;
		group.line_number = line_q;
		group.line_hits   = matches_inc;
		group.sum_valid   = (op == OP_EOF);
		group.sum_hits    = finish ? matches_inc : matches_q;
		push = step && (group.line_valid || group.sum_valid);
	end

	always_ff @(posedge clk) begin
		if (step && take && !cut_now) begin
			recent_q[0] <= data_byte;
			for (int i = 1; i < MAX_PATTERN; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q    <= '0;
			cut_q     <= 1'b0;
			matched_q <= 1'b0;
			pending_q <= 1'b0;
			line_q    <= 32'd1;
			matches_q <= '0;
		end else if (step) begin
			if (op == OP_EOF) begin
				kept_q    <= '0;
				cut_q     <= 1'b0;
				matched_q <= 1'b0;
				pending_q <= 1'b0;
				line_q    <= 32'd1;
				matches_q <= '0;
			end else if (is_newline) begin
				kept_q    <= '0;
				cut_q     <= 1'b0;
				matched_q <= 1'b0;
				pending_q <= 1'b0;
				line_q    <= line_inc;
				matches_q <= matches_inc;
			end else begin
				pending_q <= 1'b1;
				if (take) begin
					if (cut_now) begin
						cut_q <= 1'b1;
					end else begin
						kept_q <= kept_next;
						if ((eff_len != '0) && (32'(kept_next) >= 32'(eff_len)) && eq_sel) begin
							matched_q <= 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

@@ sv/lsm_out_queue.sv @@
// Two-deep queue of result groups, unpacked onto the output stream one result at a time.
module lsm_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lsm_pkg::group_t group,
	output logic            has_room,
	output logic            out_valid,
	input  logic            out_ready,
	output lsm_pkg::kind_t  out_kind,
	output logic [31:0]     out_line_number,
	output logic [31:0]     out_hit_count,
	output logic            out_last
);
	import lsm_pkg::*;

	group_t      slots_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        phase_q;
	group_t      head;
	logic        show_line;
	logic        done;
	logic        pop;

	assign has_room  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign head      = slots_q[rd_ptr_q];
	assign show_line = head.line_valid && !phase_q;

	always_comb begin
		if (show_line) begin
			out_kind        = KIND_LINE;
			out_line_number = head.line_number;
			out_hit_count   = head.line_hits;
			out_last        = !head.sum_valid;
		end else begin
			out_kind        = KIND_SUMMARY;
			out_line_number = '0;
			out_hit_count   = head.sum_hits;
			out_last        = 1'b1;
		end
	end

	assign done = out_valid && out_ready;
	assign pop  = done && !(show_line && head.sum_valid);

	always_ff @(posedge clk) begin
		if (push && has_room) begin
			slots_q[wr_ptr_q] <= group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push && has_room) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				phase_q  <= 1'b0;
			end else if (done) begin
				phase_q  <= 1'b1;
			end
			unique case ({push && has_room, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/line_substring_matcher.sv @@
// Top level of the line substring matcher: ports, configuration registers and input stage.
//
// The block takes a file as a stream of bytes, one transfer per byte, and reports each line
// that contains the configured fixed pattern, much as a fixed-string grep would. A transfer on
// the input stream with tuser low carries one file byte in tdata; with tuser high it marks the
// end of the file. A newline ends a line; at end of file a line with bytes still pending is
// ended first. Every matching line gives one result transfer (tuser low) with its one-based
// line number in tdata[31:0] and the running hit count in tdata[63:32]. End of file gives a
// summary transfer (tuser high, line number zero) with the hit count of the file, zero meaning
// no matches, and then restarts numbering. tlast marks the final result caused by an input
// transfer. Only the first LINE_BUFFER-1 bytes of a line, and none from its first zero byte
// on, are examined. An empty pattern, or one whose first byte is zero, matches every line.
// Line numbers and hit counts saturate at all ones. The block takes one byte every clock
// while the result queue has room: a byte is registered on the way in, then the window
// compare of every pattern length runs in parallel and the line state is updated, and any
// result is written into the output queue. Results wait in a two-entry queue, so input keeps
// flowing while a result is stalled; input stalls only when that queue is full, and an end of
// file that causes both a line report and a summary gives two result transfers. Configuration
// writes are accepted every cycle and should only be made while no byte is in flight.
module line_substring_matcher #(
	parameter int MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEF,
	parameter int LINE_BUFFER = lsm_pkg::LINE_BUFFER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] op
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // [31:0] line_number, [63:32] hit_count
	output logic [0:0]  m_axis_tuser,  // [0] kind
	output logic        m_axis_tlast,  // last
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import lsm_pkg::*;

	// Configuration registers.
	logic [63:0] pattern_low_q;
	logic [63:0] pattern_high_q;
	logic [4:0]  pattern_len_q;

	// Input stage.
	logic        valid_s1;
	op_t         op_s1;
	logic [7:0]  byte_s1;

	logic        step;
	logic        push;
	logic        has_room;
	group_t      group;
	kind_t       out_kind;
	logic [31:0] out_line_number;
	logic [31:0] out_hit_count;

	// The input stage empties whenever the result queue can take what the byte may cause.
	assign step          = valid_s1 && has_room;
	assign s_axis_tready = !valid_s1 || has_room;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			pattern_len_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				CFG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				CFG_PATTERN_LEN:  pattern_len_q  <= cfg_data[4:0];
				CFG_UNUSED:       pattern_len_q  <= pattern_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// The byte and its opcode carry no reset; the valid flag qualifies them.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser[0]);
			byte_s1 <= s_axis_tdata;
		end
	end

	lsm_matcher #(
		.MAX_PATTERN (MAX_PATTERN),
		.LINE_BUFFER (LINE_BUFFER)
	) u_matcher (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.op             (op_s1),
		.data_byte      (byte_s1),
		.pattern        ({pattern_high_q, pattern_low_q}),
		.pattern_length (pattern_len_q),
		.push           (push),
		.group          (group)
	);

	lsm_out_queue u_out_queue (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.group           (group),
		.has_room        (has_room),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_kind        (out_kind),
		.out_line_number (out_line_number),
		.out_hit_count   (out_hit_count),
		.out_last        (m_axis_tlast)
	);

	assign m_axis_tdata    = {out_hit_count, out_line_number};
	assign m_axis_tuser[0] = out_kind;

endmodule

@@ sv/lsm_checker.sv @@
// Port-level checks of the line substring matcher, bound to its top level.
`include "line_substring_matcher_assert.svh"

module lsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import lsm_pkg::*;

	// A summary always closes the results of its end of file.
	`LSM_ASSERT_NOW(a_summary_last, m_axis_tvalid && (m_axis_tuser[0] == KIND_SUMMARY), m_axis_tlast, "summary without tlast")
	// A summary carries no line number.
	`LSM_ASSERT_NOW(a_summary_no_line, m_axis_tvalid && (m_axis_tuser[0] == KIND_SUMMARY), m_axis_tdata[31:0] == 32'd0, "summary with line number")
	// A line report has a one-based line number and counts itself.
	`LSM_ASSERT_NOW(a_line_nonzero, m_axis_tvalid && (m_axis_tuser[0] == KIND_LINE), (m_axis_tdata[31:0] != 32'd0) && (m_axis_tdata[63:32] != 32'd0), "line report with zero field")
	// A stalled result holds.
	`LSM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind line_substring_matcher lsm_checker u_lsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/line_match_checker.sv @@
// Checker of the line substring matcher: predicts line reports and summaries and compares them.
module line_match_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fails,
	output int          backlog
);
	import lsm_pkg::*;

	localparam int WINDOW = MAX_PATTERN_DEF;
	localparam int EXAMINED = LINE_BUFFER_DEF - 1;

	typedef struct {
		kind_t       kind;
		logic [31:0] line_no;
		logic [31:0] hits;
		logic        last;
	} grep_report_t;

	grep_report_t awaited_reports [$];

	// Copy of the pattern registers.
	logic [63:0] pattern_low;
	logic [63:0] pattern_high;
	logic [4:0]  pattern_len;

	// Per-line and per-file state.
	logic [7:0]  window [WINDOW];
	int          bytes_seen;
	bit          line_stopped;
	bit          line_hit;
	bit          line_open;
	logic [31:0] line_no;
	logic [31:0] file_hits;

	function automatic logic [7:0] pattern_byte(int k);
		if (k < 8)
			return pattern_low[8*k +: 8];
		return pattern_high[8*(k-8) +: 8];
	endfunction

	// Length in use: capped at the window and cut at the first zero byte.
	function automatic int active_length();
		int n;
		n = (pattern_len > WINDOW) ? WINDOW : int'(pattern_len);
		for (int k = 0; k < n; k++)
			if (pattern_byte(k) == 8'h00)
				return k;
		return n;
	endfunction

	function automatic grep_report_t report(kind_t k, logic [31:0] ln, logic [31:0] h);
		grep_report_t r;
		r.kind = k;
		r.line_no = ln;
		r.hits = h;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic clear_line_state();
		foreach (window[i])
			window[i] = 8'h00;
		bytes_seen = 0;
		line_stopped = 1'b0;
		line_hit = 1'b0;
		line_open = 1'b0;
	endtask

	task automatic close_line(inout int produced);
		if (line_hit || active_length() == 0) begin
			if (file_hits != SAT32)
				file_hits++;
			awaited_reports.push_back(report(KIND_LINE, line_no, file_hits));
			produced++;
		end
		if (line_no != SAT32)
			line_no++;
		clear_line_state();
	endtask

	task automatic scan_byte(logic [7:0] b);
		int n;
		bit same;
		line_open = 1'b1;
		if (line_stopped)
			return;
		if (b == 8'h00 || bytes_seen >= EXAMINED) begin
			line_stopped = 1'b1;
			return;
		end
		for (int i = WINDOW - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = b;
		bytes_seen++;
		n = active_length();
		if (n == 0 || bytes_seen < n)
			return;
		same = 1'b1;
		for (int i = 0; i < n; i++)
			if (window[i] != pattern_byte(n - 1 - i))
				same = 1'b0;
		if (same)
			line_hit = 1'b1;
	endtask

	task automatic take_item(op_t op, logic [7:0] b);
		int produced;
		produced = 0;
		if (op == OP_BYTE) begin
			if (b == NEWLINE_BYTE)
				close_line(produced);
			else
				scan_byte(b);
		end else begin
			if (line_open)
				close_line(produced);
			awaited_reports.push_back(report(KIND_SUMMARY, 32'd0, file_hits));
			produced++;
			clear_line_state();
			line_no = 32'd1;
			file_hits = 32'd0;
		end
		if (produced > 0)
			awaited_reports[awaited_reports.size()-1].last = 1'b1;
	endtask

	task automatic check_report();
		grep_report_t want;
		if (awaited_reports.size() == 0) begin
			$display("%0t: unexpected result, expected none, got kind %0d line %0d hits %0d last %0b",
				$time, m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
			fails++;
		end else begin
			want = awaited_reports.pop_front();
			if (want.kind != m_axis_tuser[0] || want.line_no != m_axis_tdata[31:0] ||
			    want.hits != m_axis_tdata[63:32] || want.last != m_axis_tlast) begin
				$display("%0t: result mismatch, expected kind %0d line %0d hits %0d last %0b",
					$time, want.kind, want.line_no, want.hits, want.last);
				$display("%0t: result mismatch, actual   kind %0d line %0d hits %0d last %0b",
					$time, m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[63:32],
					m_axis_tlast);
				fails++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low = 64'd0;
			pattern_high = 64'd0;
			pattern_len = 5'd0;
			clear_line_state();
			line_no = 32'd1;
			file_hits = 32'd0;
			awaited_reports.delete();
			fails = 0;
			backlog = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_PATTERN_LOW:  pattern_low = cfg_data;
					CFG_PATTERN_HIGH: pattern_high = cfg_data;
					CFG_PATTERN_LEN:  pattern_len = cfg_data[4:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				take_item(op_t'(s_axis_tuser[0]), s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_report();
			backlog = awaited_reports.size();
		end
	end

endmodule

@@ tb/sv/line_substring_matcher_test.sv @@
// Testbench top of the line substring matcher: clock, reset, stimulus and verdict.
module line_substring_matcher_test;
	import lsm_pkg::*;

	// Generous bound on the whole run.
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 1550;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic [0:0]  s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [63:0] cfg_data = 64'd0;

	int fails;
	int backlog;
	int cycle_count = 0;
	int items = 0;
	int ready_hold = 0;
	bit result_taken = 1'b0;

	// When set, neither side idles: back-to-back transfers in both directions.
	bit quiet = 1'b0;

	// The pattern as last written, and how many of its bytes are in use, so that lines can
	// be built which contain it.
	logic [7:0] pattern [16];
	int         embed_len = 0;

	always #5 clk = ~clk;

	line_substring_matcher i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	line_match_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fails         (fails),
		.backlog       (backlog)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: after every accepted result the receiver draws a random stall, none when quiet,
	// which is then played out one falling edge at a time.
	always @(posedge clk)
		result_taken <= m_axis_tvalid && m_axis_tready;

	always @(negedge clk) begin
		if (result_taken)
			ready_hold = quiet ? 0 : $urandom_range(0, 10);
		if (ready_hold > 0) begin
			m_axis_tready <= 1'b0;
			ready_hold = ready_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Presents one input item after a random gap and returns at the edge where it is taken.
	// tvalid stays high afterwards, so that the next item can follow without a bubble; only
	// one assignment to it is made at any falling edge.
	task automatic send_item(op_t op, logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items++;
	endtask

	// Withdraws the input, waits for every predicted result, then lets the pipeline drain of
	// items that cause no result before anything touches the registers.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (backlog == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pattern(logic [63:0] low, logic [63:0] high, logic [63:0] len_word);
		settle();
		write_reg(CFG_PATTERN_LOW, low);
		write_reg(CFG_PATTERN_HIGH, high);
		write_reg(CFG_PATTERN_LEN, len_word);
		for (int k = 0; k < 16; k++)
			pattern[k] = (k < 8) ? low[8*k +: 8] : high[8*(k-8) +: 8];
		embed_len = (len_word[4:0] > 16) ? 16 : int'(len_word[4:0]);
		for (int k = 15; k >= 0; k--)
			if (k < embed_len && pattern[k] == 8'h00)
				embed_len = k;
	endtask

	// Patterns are drawn mostly short and from a small alphabet, so that hits are frequent;
	// a few are empty, overlong, all ones or carry a zero byte.
	task automatic program_random_pattern();
		logic [7:0]  pb [16];
		logic [63:0] low;
		logic [63:0] high;
		logic [63:0] len_word;
		int          len;
		case ($urandom_range(0, 9))
			0: len = 0;
			1: len = $urandom_range(17, 31);
			2, 3: len = $urandom_range(5, 16);
			default: len = $urandom_range(1, 4);
		endcase
		for (int k = 0; k < 16; k++)
			pb[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
			                                     : 8'(8'h61 + $urandom_range(0, 2));
		if ($urandom_range(0, 7) == 0)
			for (int k = 0; k < 16; k++)
				pb[k] = 8'hFF;
		if ($urandom_range(0, 7) == 0)
			pb[$urandom_range(0, 15)] = 8'h00;
		for (int k = 0; k < 8; k++) begin
			low[8*k +: 8] = pb[k];
			high[8*k +: 8] = pb[k+8];
		end
		len_word = 64'(len);
		// Bits above the length field are don't-care to the block; exercise them now and then.
		if ($urandom_range(0, 3) == 0)
			len_word[63:5] = 59'({$urandom, $urandom});
		set_pattern(low, high, len_word);
	endtask

	// Line text: pattern bytes, a small alphabet, any byte, and now and then a zero byte.
	function automatic logic [7:0] filler();
		int pick;
		pick = $urandom_range(0, 49);
		if (pick < 20 && embed_len > 0)
			return pattern[$urandom_range(0, embed_len - 1)];
		if (pick < 40)
			return 8'(8'h61 + $urandom_range(0, 2));
		if (pick == 49)
			return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// One line, usually short, rarely longer than the examined part; it often contains the
	// pattern and is sometimes left without its newline, to be ended by end of file or
	// continued after a register write.
	task automatic send_line();
		logic [7:0] text [$];
		int         len;
		int         pos;
		if ($urandom_range(0, 59) == 0)
			len = $urandom_range(250, 300);
		else
			len = $urandom_range(0, 24);
		for (int i = 0; i < len; i++)
			text.push_back(filler());
		if (embed_len > 0 && len >= embed_len && $urandom_range(0, 2) != 0) begin
			pos = $urandom_range(0, len - embed_len);
			for (int k = 0; k < embed_len; k++)
				text[pos+k] = pattern[k];
		end
		foreach (text[i])
			send_item(OP_BYTE, text[i]);
		if ($urandom_range(0, 5) != 0)
			send_item(OP_BYTE, NEWLINE_BYTE);
	endtask

	initial begin
		int guard;
		int lines;
		for (int k = 0; k < 16; k++)
			pattern[k] = 8'h00;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// After reset the pattern is empty, so every line matches: an empty line, then an
		// unterminated line ended by end of file, then an end of file with nothing pending.
		send_item(OP_BYTE, NEWLINE_BYTE);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_EOF, 8'h00);
		send_item(OP_EOF, 8'hFF);

		// A write to the spare index must leave the pattern alone.
		settle();
		write_reg(CFG_UNUSED, '1);

		// Pattern "ab": a hit at the end of a line, an empty line that misses, and a line
		// whose zero byte hides the pattern that follows it.
		set_pattern(64'hFFFF_FFFF_FFFF_6261, '1, 64'd2);
		send_item(OP_BYTE, 8'h78);
		send_item(OP_BYTE, 8'h61);
		send_item(OP_BYTE, 8'h62);
		send_item(OP_BYTE, NEWLINE_BYTE);
		send_item(OP_BYTE, NEWLINE_BYTE);
		send_item(OP_BYTE, 8'h61);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h61);
		send_item(OP_BYTE, 8'h62);
		send_item(OP_BYTE, NEWLINE_BYTE);
		send_item(OP_BYTE, 8'h61);
		send_item(OP_BYTE, 8'h62);
		send_item(OP_EOF, 8'h00);

		// A length beyond the window, with a zero second byte: the pattern is just "a".
		set_pattern(64'hFFFF_FFFF_FF00_0061, 64'd0, 64'd31);
		send_item(OP_BYTE, 8'h61);
		send_item(OP_EOF, 8'h55);

		// Random files. A phase may rewrite the pattern in the middle of a file, even in the
		// middle of a line, and may leave the file open for the next phase.
		while (items < RANDOM_ITEMS + 19) begin
			quiet = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 2) != 0)
				program_random_pattern();
			lines = $urandom_range(1, 8);
			repeat (lines) send_line();
			if ($urandom_range(0, 2) != 0)
				send_item(OP_EOF, 8'($urandom_range(0, 255)));
		end
		quiet = 1'b0;
		send_item(OP_EOF, 8'($urandom_range(0, 255)));

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		for (guard = 0; guard < 10000 && backlog != 0; guard++)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (fails == 0 && backlog == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
